// ===== design/affinity_priority_ready_queue_core_defines.svh =====
// Assertion macros shared by the queue RTL.
`ifndef AFFINITY_PRIORITY_READY_QUEUE_CORE_DEFINES_SVH
`define AFFINITY_PRIORITY_READY_QUEUE_CORE_DEFINES_SVH

`ifndef SYNTH
`define APQ_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define APQ_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) else $error(msg);
`else
`define APQ_ASSERT(lbl, clk, rstn, prop, msg)
`define APQ_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg)
`endif

`endif

// ===== design/apq_pkg.sv =====
package apq_pkg;

    localparam int QUEUE_DEPTH  = 64;
    localparam int WORKER_COUNT = 16;
    localparam int CNT_W        = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] FUNC_INSERT = 2'd0;
    localparam logic [1:0] FUNC_REMOVE = 2'd1;
    localparam logic [1:0] FUNC_CLAIM  = 2'd2;

    localparam logic [1:0] STAT_DONE = 2'd0;
    localparam logic [1:0] STAT_FULL = 2'd1;
    localparam logic [1:0] STAT_NONE = 2'd2;

    localparam logic [4:0] AFF_ANY = 5'h1F;

    typedef struct packed {
        logic [1:0]  func;
        logic [15:0] tag;
        logic [7:0]  prio;
        logic [31:0] order;
        logic [4:0]  aff;
        logic [3:0]  worker;
    } t_cmd;

    typedef struct packed {
        logic        valid;
        logic [15:0] tag;
        logic [7:0]  prio;
        logic [31:0] order;
        logic [4:0]  aff;
    } t_entry;

endpackage

// ===== design/apq_cell.sv =====
module apq_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  apq_pkg::t_cmd   i_cmd,
    input  logic            i_eval,
    input  logic            i_commit,
    input  logic            i_prev_hit,
    input  apq_pkg::t_entry i_left,
    input  apq_pkg::t_entry i_right,
    output apq_pkg::t_entry o_entry,
    output logic            o_hit
);

    apq_pkg::t_entry r_entry;
    apq_pkg::t_entry n_entry;
    apq_pkg::t_entry w_new;
    logic            r_hit;
    logic            n_hit;
    logic            w_worker_ok;

    assign w_worker_ok = (32'(i_cmd.worker) < apq_pkg::WORKER_COUNT);

    always_comb begin
        w_new.valid = 1'b1;
        w_new.tag   = i_cmd.tag;
        w_new.prio  = i_cmd.prio;
        w_new.order = i_cmd.order;
        w_new.aff   = i_cmd.aff;
    end

    // An insert marks every cell that belongs after the new task.
    always_comb begin
        unique case (i_cmd.func)
            apq_pkg::FUNC_INSERT: begin
                n_hit = !r_entry.valid
                     || ($signed(r_entry.prio) < $signed(i_cmd.prio))
                     || (r_entry.prio == i_cmd.prio && r_entry.order > i_cmd.order);
            end
            apq_pkg::FUNC_REMOVE: begin
                n_hit = r_entry.valid && (r_entry.tag == i_cmd.tag);
            end
            apq_pkg::FUNC_CLAIM: begin
                n_hit = r_entry.valid && w_worker_ok
                     && (r_entry.aff == apq_pkg::AFF_ANY
                         || r_entry.aff == {1'b0, i_cmd.worker});
            end
            default: begin
                n_hit = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_entry = r_entry;
        if (i_commit) begin
            if (i_cmd.func == apq_pkg::FUNC_INSERT) begin
                if (i_prev_hit) begin
                    n_entry = i_left;
                end else if (r_hit) begin
                    n_entry = w_new;
                end
            end else if (i_prev_hit || r_hit) begin
                n_entry = i_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry.valid <= 1'b0;
            r_hit         <= 1'b0;
        end else begin
            r_entry <= n_entry;
            if (i_eval) begin
                r_hit <= n_hit;
            end
        end
    end

    assign o_entry = r_entry;
    assign o_hit   = r_hit;

endmodule

// ===== design/apq_prefix.sv =====
module apq_prefix (
    input  logic [apq_pkg::QUEUE_DEPTH-1:0] i_hit,
    output logic [apq_pkg::QUEUE_DEPTH-1:0] o_prev,
    output logic                            o_any
);

    localparam int STAGES = $clog2(apq_pkg::QUEUE_DEPTH);

    logic [apq_pkg::QUEUE_DEPTH-1:0] w_lvl [STAGES+1];

    // Log-step prefix OR: bit i ends up as the OR of hits 0 through i.
    always_comb begin
        w_lvl[0] = i_hit;
        for (int s = 0; s < STAGES; s++) begin
            w_lvl[s+1] = w_lvl[s] | (w_lvl[s] << (1 << s));
        end
    end

    assign o_prev = w_lvl[STAGES] << 1;
    assign o_any  = w_lvl[STAGES][apq_pkg::QUEUE_DEPTH-1];

endmodule

// ===== design/affinity_priority_ready_queue_core.sv =====
// Channel  Handshake                  Beat payload
// -------  -------------------------  -------------------------------------------------
// in       i_in_valid / o_in_ready    i_func i_task_tag i_priority_req i_submit_order
//                                     i_affinity i_worker
// out      o_out_valid / i_out_ready  o_status o_claimed_valid o_claimed_tag o_occupancy
//
// Each beat passes through a capture step, a match pass in every cell, and a commit pass
// in which the cells shift toward or away from the match point.
// The commit pass waits while the previous result is still held on the output.
// A new beat is taken once the commit of the previous one is done.
// Reset clears the cell valid bits, the fill count and the control state.
`include "affinity_priority_ready_queue_core_defines.svh"

module affinity_priority_ready_queue_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_func,
    input  logic [15:0] i_task_tag,
    input  logic signed [7:0]  i_priority_req,
    input  logic [31:0] i_submit_order,
    input  logic signed [4:0]  i_affinity,
    input  logic [3:0]  i_worker,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic        o_claimed_valid,
    output logic [15:0] o_claimed_tag,
    output logic [6:0]  o_occupancy
);

    localparam int DEPTH = apq_pkg::QUEUE_DEPTH;

    typedef enum logic [1:0] {ST_IDLE, ST_EVAL, ST_COMMIT} t_state;

    t_state                  r_state;
    apq_pkg::t_cmd           r_cmd;
    logic [apq_pkg::CNT_W-1:0] r_count;
    logic [apq_pkg::CNT_W-1:0] n_count;
    logic                    r_out_valid;
    logic [1:0]              r_status;
    logic                    r_claimed_valid;
    logic [15:0]             r_claimed_tag;
    logic [6:0]              r_occupancy;

    apq_pkg::t_entry         w_entry [DEPTH];
    logic [DEPTH-1:0]        w_hit;
    logic [DEPTH-1:0]        w_prev;
    logic [DEPTH-1:0]        w_valid;
    logic                    w_any;
    logic                    w_full;
    logic                    w_commit_go;
    logic                    w_cell_commit;
    logic                    w_accept;
    logic [15:0]             w_first_tag;
    logic [1:0]              n_status;

    assign w_accept      = i_in_valid && o_in_ready;
    assign w_full        = w_entry[DEPTH-1].valid;
    assign w_commit_go   = (r_state == ST_COMMIT) && (!r_out_valid || i_out_ready);
    assign w_cell_commit = w_commit_go && !(r_cmd.func == apq_pkg::FUNC_INSERT && w_full);

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        apq_pkg::t_entry w_left;
        apq_pkg::t_entry w_right;
        if (g == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_entry[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_entry[g+1];
        end
        apq_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_cmd      (r_cmd),
            .i_eval     (r_state == ST_EVAL),
            .i_commit   (w_cell_commit),
            .i_prev_hit (w_prev[g]),
            .i_left     (w_left),
            .i_right    (w_right),
            .o_entry    (w_entry[g]),
            .o_hit      (w_hit[g])
        );
        assign w_valid[g] = w_entry[g].valid;
    end

    apq_prefix u_prefix (
        .i_hit  (w_hit),
        .o_prev (w_prev),
        .o_any  (w_any)
    );

    always_comb begin
        w_first_tag = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (w_hit[i] && !w_prev[i]) begin
                w_first_tag = w_first_tag | w_entry[i].tag;
            end
        end
    end

    always_comb begin
        n_status = apq_pkg::STAT_NONE;
        n_count  = r_count;
        unique case (r_cmd.func)
            apq_pkg::FUNC_INSERT: begin
                if (w_full) begin
                    n_status = apq_pkg::STAT_FULL;
                end else begin
                    n_status = apq_pkg::STAT_DONE;
                    n_count  = r_count + 1'b1;
                end
            end
            apq_pkg::FUNC_REMOVE, apq_pkg::FUNC_CLAIM: begin
                if (w_any) begin
                    n_status = apq_pkg::STAT_DONE;
                    n_count  = r_count - 1'b1;
                end
            end
            default: begin
                n_status = apq_pkg::STAT_NONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_commit_go) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_cmd.func   <= i_func;
                        r_cmd.tag    <= i_task_tag;
                        r_cmd.prio   <= i_priority_req;
                        r_cmd.order  <= i_submit_order;
                        r_cmd.aff    <= i_affinity;
                        r_cmd.worker <= i_worker;
                        r_state      <= ST_EVAL;
                    end
                end
                ST_EVAL: begin
                    r_state <= ST_COMMIT;
                end
                ST_COMMIT: begin
                    if (w_commit_go) begin
                        r_status        <= n_status;
                        r_claimed_valid <= (r_cmd.func == apq_pkg::FUNC_CLAIM) && w_any;
                        r_claimed_tag   <= (r_cmd.func == apq_pkg::FUNC_CLAIM && w_any)
                                         ? w_first_tag : 16'd0;
                        r_occupancy     <= 7'(n_count);
                        r_count         <= n_count;
                        r_state         <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready      = (r_state == ST_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_claimed_valid = r_claimed_valid;
    assign o_claimed_tag   = r_claimed_tag;
    assign o_occupancy     = r_occupancy;

    `APQ_ASSERT(a_count_matches, i_clk, i_rst_n, $countones(w_valid) == int'(r_count), "fill count differs from valid cells")
    `APQ_ASSERT(a_valid_prefix, i_clk, i_rst_n, (w_valid & (w_valid + 1'b1)) == '0, "valid cells do not form a prefix")
    `APQ_ASSERT(a_claim_done, i_clk, i_rst_n, !(o_out_valid && o_claimed_valid) || o_status == apq_pkg::STAT_DONE, "claimed task without done status")
    `APQ_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, r_state == ST_COMMIT && !w_commit_go, r_state == ST_COMMIT && $stable(w_valid), "cells changed during output stall")

endmodule
